// File: src/waq_pkg.sv
// Package for the warning annunciator queue: codes, colors, limits and shared types.
package waq_pkg;

   // Queue shape and field widths
   localparam int QDEPTH      = 3;
   localparam int CODE_BITS   = 2;
   localparam int OIL_BITS    = 12;
   localparam int COOL_BITS   = 11;
   localparam int NOW_BITS    = 32;
   localparam int SHOW_BITS   = 16;
   localparam int VALUE_BITS  = 13;
   localparam int COLOR_BITS  = 16;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   // Warning codes
   localparam logic [CODE_BITS-1:0] CODE_NONE     = 2'd0;
   localparam logic [CODE_BITS-1:0] CODE_LOW_OIL  = 2'd1;
   localparam logic [CODE_BITS-1:0] CODE_HIGH_OIL = 2'd2;
   localparam logic [CODE_BITS-1:0] CODE_HOT      = 2'd3;

   // RGB565 colors
   localparam logic [COLOR_BITS-1:0] COLOR_YELLOW = 16'hFFE0;
   localparam logic [COLOR_BITS-1:0] COLOR_ORANGE = 16'hFD00;
   localparam logic [COLOR_BITS-1:0] COLOR_RED    = 16'hF800;

   // Register indexes (byte address / 4)
   localparam logic [1:0] REG_LOW_OIL  = 2'd0;
   localparam logic [1:0] REG_HIGH_OIL = 2'd1;
   localparam logic [1:0] REG_HOT      = 2'd2;
   localparam logic [1:0] REG_MIN_SHOW = 2'd3;

   // Register reset values
   localparam logic [OIL_BITS-1:0]  LOW_OIL_RESET  = 12'd100;
   localparam logic [OIL_BITS-1:0]  HIGH_OIL_RESET = 12'd550;
   localparam logic [COOL_BITS-1:0] HOT_RESET      = 11'd230;
   localparam logic [SHOW_BITS-1:0] MIN_SHOW_RESET = 16'd5000;

   // Mask of raised warnings, bit 0 low oil, bit 1 high oil, bit 2 high coolant
   typedef logic [QDEPTH-1:0] code_mask_type;

   // Content of one queue cell
   typedef struct packed {
      logic                 valid;
      logic [CODE_BITS-1:0] code;
   } cell_link_type;

   // Display state
   typedef enum logic {
      DISP_IDLE,
      DISP_SHOW
   } disp_state_type;

   // One-hot mask bit of a code
   function automatic code_mask_type code_bit(input logic [CODE_BITS-1:0] code);
      code_mask_type m;
      m = '0;
      case (code)
         CODE_LOW_OIL:  m = 3'b001;
         CODE_HIGH_OIL: m = 3'b010;
         CODE_HOT:      m = 3'b100;
         default:       m = '0;
      endcase
      return m;
   endfunction

   // Display color of a code
   function automatic logic [COLOR_BITS-1:0] code_color(input logic [CODE_BITS-1:0] code);
      logic [COLOR_BITS-1:0] c;
      c = '0;
      case (code)
         CODE_LOW_OIL:  c = COLOR_YELLOW;
         CODE_HIGH_OIL: c = COLOR_ORANGE;
         CODE_HOT:      c = COLOR_RED;
         default:       c = '0;
      endcase
      return c;
   endfunction

endpackage

// File: src/waq_req_if.sv
// Request channel: one monitoring tick with oil, coolant and time samples.
interface waq_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [waq_pkg::OIL_BITS-1:0]         oil_kpa;
   logic signed [waq_pkg::COOL_BITS-1:0] coolant_f;
   logic [waq_pkg::NOW_BITS-1:0]         now_ms;

   modport source (output valid, output oil_kpa, output coolant_f, output now_ms,
                   input ready);
   modport sink (input valid, input oil_kpa, input coolant_f, input now_ms,
                 output ready);
endinterface

// File: src/waq_rsp_if.sv
// Response channel: display status after one monitoring tick.
interface waq_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  showing;
   logic [waq_pkg::CODE_BITS-1:0]         warn_code;
   logic signed [waq_pkg::VALUE_BITS-1:0] warn_value;
   logic [waq_pkg::COLOR_BITS-1:0]        warn_color;
   logic [waq_pkg::CODE_BITS-1:0]         pending;
   logic                                  go_home;

   modport source (output valid, output showing, output warn_code, output warn_value,
                   output warn_color, output pending, output go_home, input ready);
   modport sink (input valid, input showing, input warn_code, input warn_value,
                 input warn_color, input pending, input go_home, output ready);
endinterface

// File: src/waq_cell.sv
// One queue cell: dedups and claims raised codes, shifts toward the head on pop.
module waq_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic                   pop,
   input  waq_pkg::code_mask_type mask_in,
   output waq_pkg::code_mask_type mask_out,
   input  waq_pkg::cell_link_type shift_in,
   output waq_pkg::cell_link_type post_out
);

   logic                          valid_ff, valid_in;
   logic [waq_pkg::CODE_BITS-1:0] code_ff, code_in;

   // Drop own code from the raised mask, or claim the lowest raised code if empty
   always_comb begin
      post_out.valid = valid_ff;
      post_out.code  = code_ff;
      mask_out       = mask_in;
      if (valid_ff) begin
         mask_out = mask_in & ~waq_pkg::code_bit(code_ff);
      end else if (mask_in[0]) begin
         post_out.valid = 1'b1;
         post_out.code  = waq_pkg::CODE_LOW_OIL;
         mask_out       = mask_in & 3'b110;
      end else if (mask_in[1]) begin
         post_out.valid = 1'b1;
         post_out.code  = waq_pkg::CODE_HIGH_OIL;
         mask_out       = mask_in & 3'b100;
      end else if (mask_in[2]) begin
         post_out.valid = 1'b1;
         post_out.code  = waq_pkg::CODE_HOT;
         mask_out       = '0;
      end
   end

   // On an accepted request take the neighbor's content on pop, else the own or claimed code; otherwise keep own
   always_comb begin
      valid_in = valid_ff;
      code_in  = code_ff;
      if (accept) begin
         if (pop) begin
            valid_in = shift_in.valid;
            code_in  = shift_in.code;
         end else begin
            valid_in = post_out.valid;
            code_in  = post_out.code;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         code_ff  <= waq_pkg::CODE_NONE;
      end else begin
         valid_ff <= valid_in;
         code_ff  <= code_in;
      end
   end

endmodule

// File: src/warning_annunciator_queue.sv
// Top level of the warning annunciator queue: limit checks, cell chain, display control.
//
//   channel   dir   handshake              payload
//   req_bus   in    valid/ready            oil_kpa, coolant_f, now_ms
//   rsp_bus   out   valid/ready            showing, warn_code, warn_value, warn_color,
//                                          pending, go_home
//   csr_*     in    APB psel/penable       four limit and timing registers, 4-byte stride
//
// One request per cycle: the limit checks, the three-cell queue and the display
// state all settle combinationally; the response sits in an output register.
// req_bus.ready is high while that register is empty or being taken this cycle.
// Synchronous reset clears the queue, display state and response valid, and loads the registers' reset values.
// A stalled response holds its payload and blocks new requests until it is taken.
module warning_annunciator_queue #(
   parameter int TIME_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   waq_req_if.sink                             req_bus,
   waq_rsp_if.source                           rsp_bus,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [waq_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [waq_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [waq_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready
);

   // Configuration registers
   logic [waq_pkg::OIL_BITS-1:0]         low_oil_ff;
   logic [waq_pkg::OIL_BITS-1:0]         high_oil_ff;
   logic signed [waq_pkg::COOL_BITS-1:0] hot_ff;
   logic [waq_pkg::SHOW_BITS-1:0]        min_show_ff;

   // Display state
   waq_pkg::disp_state_type state_ff, state_in;
   logic [TIME_BITS-1:0]    since_ff, since_in;

   // Response register
   logic                                  rsp_valid_ff;
   logic                                  showing_ff, showing_in;
   logic [waq_pkg::CODE_BITS-1:0]         code_ff, code_in;
   logic signed [waq_pkg::VALUE_BITS-1:0] value_ff, value_in;
   logic [waq_pkg::COLOR_BITS-1:0]        color_ff, color_in;
   logic [waq_pkg::CODE_BITS-1:0]         pending_ff, pending_in;
   logic                                  home_ff, home_in;

   logic accept;
   logic csr_write;
   logic cond_low, cond_high, cond_hot, head_cond;
   logic pop, since_load;
   logic [63:0]          now_wide;
   logic [63:0]          min_wide;
   logic [TIME_BITS-1:0] now_t;
   logic [TIME_BITS-1:0] elapsed;
   logic [TIME_BITS-1:0] min_t;
   logic                 time_up;
   logic [waq_pkg::CODE_BITS-1:0] len_post;
   logic [waq_pkg::CODE_BITS-1:0] head_code;
   logic [waq_pkg::QDEPTH-1:0]    post_valid;

   waq_pkg::code_mask_type mask_link [waq_pkg::QDEPTH+1];
   waq_pkg::cell_link_type post_link [waq_pkg::QDEPTH+1];

   // Handshake
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   // Limit checks
   assign cond_low  = req_bus.oil_kpa < low_oil_ff;
   assign cond_high = req_bus.oil_kpa > high_oil_ff;
   assign cond_hot  = req_bus.coolant_f > hot_ff;

   // Cell chain: raised mask flows from head to tail, shifted content from tail to head
   assign mask_link[0]              = {cond_hot, cond_high, cond_low};
   assign post_link[waq_pkg::QDEPTH] = '0;

   for (genvar i = 0; i < waq_pkg::QDEPTH; i++) begin : g_cell
      waq_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .accept   (accept),
         .pop      (pop),
         .mask_in  (mask_link[i]),
         .mask_out (mask_link[i+1]),
         .shift_in (post_link[i+1]),
         .post_out (post_link[i])
      );
      assign post_valid[i] = post_link[i].valid;
   end

   assign len_post  = waq_pkg::CODE_BITS'($countones(post_valid));
   assign head_code = post_link[0].code;

   // Elapsed time modulo 2^TIME_BITS
   assign now_wide = 64'(req_bus.now_ms);
   assign min_wide = 64'(min_show_ff);
   assign now_t    = now_wide[TIME_BITS-1:0];
   assign min_t    = min_wide[TIME_BITS-1:0];
   assign elapsed  = now_t - since_ff;
   assign time_up  = elapsed >= min_t;

   // Condition of the head warning
   always_comb begin
      case (head_code)
         waq_pkg::CODE_LOW_OIL:  head_cond = cond_low;
         waq_pkg::CODE_HIGH_OIL: head_cond = cond_high;
         waq_pkg::CODE_HOT:      head_cond = cond_hot;
         default:                head_cond = 1'b0;
      endcase
   end

   // Next display state, pop and timer restart
   always_comb begin
      state_in   = state_ff;
      pop        = 1'b0;
      since_load = 1'b0;
      home_in    = 1'b0;
      unique case (state_ff)
         waq_pkg::DISP_IDLE: begin
            if (len_post != '0) begin
               state_in   = waq_pkg::DISP_SHOW;
               since_load = 1'b1;
            end
         end
         waq_pkg::DISP_SHOW: begin
            if (len_post == '0) begin
               state_in = waq_pkg::DISP_IDLE;
            end else if (time_up) begin
               if (len_post > 2'd1) begin
                  pop      = 1'b1;
                  state_in = waq_pkg::DISP_IDLE;
               end else if (!head_cond) begin
                  pop      = 1'b1;
                  state_in = waq_pkg::DISP_IDLE;
                  home_in  = 1'b1;
               end else begin
                  since_load = 1'b1;
               end
            end
         end
         default: state_in = waq_pkg::DISP_IDLE;
      endcase
   end

   assign since_in = since_load ? now_t : since_ff;

   // Response fields
   always_comb begin
      showing_in = (state_in == waq_pkg::DISP_SHOW) && (len_post != '0);
      pending_in = len_post - waq_pkg::CODE_BITS'(pop);
      code_in    = showing_in ? head_code : waq_pkg::CODE_NONE;
      color_in   = waq_pkg::code_color(code_in);
      case (code_in) inside
         waq_pkg::CODE_LOW_OIL,
         waq_pkg::CODE_HIGH_OIL: value_in = $signed({1'b0, req_bus.oil_kpa});
         waq_pkg::CODE_HOT:      value_in = waq_pkg::VALUE_BITS'(req_bus.coolant_f);
         default:                value_in = '0;
      endcase
   end

   // Advance display state on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= waq_pkg::DISP_IDLE;
         since_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
         since_ff <= since_in;
      end
   end

   // Hold the response until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         showing_ff <= showing_in;
         code_ff    <= code_in;
         value_ff   <= value_in;
         color_ff   <= color_in;
         pending_ff <= pending_in;
         home_ff    <= home_in;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.showing    = showing_ff;
   assign rsp_bus.warn_code  = code_ff;
   assign rsp_bus.warn_value = value_ff;
   assign rsp_bus.warn_color = color_ff;
   assign rsp_bus.pending    = pending_ff;
   assign rsp_bus.go_home    = home_ff;

   // Register writes
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_oil_ff  <= waq_pkg::LOW_OIL_RESET;
         high_oil_ff <= waq_pkg::HIGH_OIL_RESET;
         hot_ff      <= waq_pkg::HOT_RESET;
         min_show_ff <= waq_pkg::MIN_SHOW_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            waq_pkg::REG_LOW_OIL:  low_oil_ff  <= csr_pwdata[waq_pkg::OIL_BITS-1:0];
            waq_pkg::REG_HIGH_OIL: high_oil_ff <= csr_pwdata[waq_pkg::OIL_BITS-1:0];
            waq_pkg::REG_HOT:      hot_ff      <= $signed(csr_pwdata[waq_pkg::COOL_BITS-1:0]);
            waq_pkg::REG_MIN_SHOW: min_show_ff <= csr_pwdata[waq_pkg::SHOW_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Register reads
   always_comb begin
      unique case (csr_paddr[3:2])
         waq_pkg::REG_LOW_OIL:  csr_prdata = waq_pkg::CSR_DATA_BITS'(low_oil_ff);
         waq_pkg::REG_HIGH_OIL: csr_prdata = waq_pkg::CSR_DATA_BITS'(high_oil_ff);
         waq_pkg::REG_HOT:      csr_prdata = waq_pkg::CSR_DATA_BITS'($unsigned(hot_ff));
         waq_pkg::REG_MIN_SHOW: csr_prdata = waq_pkg::CSR_DATA_BITS'(min_show_ff);
         default:               csr_prdata = '0;
      endcase
   end

endmodule

// File: bench/warning_annunciator_queue_tb.sv
// Self-checking bench for the warning annunciator queue: directed ticks, then random phases.
`timescale 1ns / 100ps

module warning_annunciator_queue_tb;

   // One display status, as the response channel carries it
   typedef struct packed {
      logic                                  showing;
      logic [waq_pkg::CODE_BITS-1:0]         warn_code;
      logic signed [waq_pkg::VALUE_BITS-1:0] warn_value;
      logic [waq_pkg::COLOR_BITS-1:0]        warn_color;
      logic [waq_pkg::CODE_BITS-1:0]         pending;
      logic                                  go_home;
   } panel_status_type;

   // One directed tick; the status is typed in only where marked
   typedef struct packed {
      logic [waq_pkg::OIL_BITS-1:0]         oil;
      logic signed [waq_pkg::COOL_BITS-1:0] cool;
      logic [waq_pkg::NOW_BITS-1:0]         now;
      logic                                 typed;
      panel_status_type                     want;
   } tick_row_type;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [waq_pkg::CSR_ADDR_BITS-1:0] csr_paddr;
   logic [waq_pkg::CSR_DATA_BITS-1:0] csr_pwdata;
   logic [waq_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   waq_req_if req_bus ();
   waq_rsp_if rsp_bus ();

   warning_annunciator_queue #(
      .TIME_BITS(32)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // Shadow of the limit registers
   logic [waq_pkg::OIL_BITS-1:0]         lim_low_oil  = waq_pkg::LOW_OIL_RESET;
   logic [waq_pkg::OIL_BITS-1:0]         lim_high_oil = waq_pkg::HIGH_OIL_RESET;
   logic signed [waq_pkg::COOL_BITS-1:0] lim_hot      = waq_pkg::HOT_RESET;
   logic [waq_pkg::SHOW_BITS-1:0]        min_show     = waq_pkg::MIN_SHOW_RESET;

   // Shadow of the warning queue and display state
   logic [waq_pkg::CODE_BITS-1:0] shadow_codes [waq_pkg::QDEPTH] =
      '{waq_pkg::CODE_NONE, waq_pkg::CODE_NONE, waq_pkg::CODE_NONE};
   logic [1:0]                    shadow_len    = '0;
   logic                          shadow_active = 1'b0;
   logic [waq_pkg::NOW_BITS-1:0]  shadow_since  = '0;

   logic [waq_pkg::COLOR_BITS-1:0] shade [4] =
      '{16'h0000, waq_pkg::COLOR_YELLOW, waq_pkg::COLOR_ORANGE, waq_pkg::COLOR_RED};

   panel_status_type status_due [$];
   int               fault_count = 0;
   bit               calm = 1'b0;
   logic [waq_pkg::NOW_BITS-1:0] clock_ms = '0;

   // Reset-value walk, limit boundaries, time wrap and duplicate pushes
   tick_row_type directed_ticks [16] = '{
      '{12'd300,  11'sd100,   32'd0,     1'b1,
        '{1'b0, waq_pkg::CODE_NONE, 13'sd0, 16'h0000, 2'd0, 1'b0}},
      '{12'd0,    11'sd100,   32'd10,    1'b1,
        '{1'b1, waq_pkg::CODE_LOW_OIL, 13'sd0, waq_pkg::COLOR_YELLOW, 2'd1, 1'b0}},
      '{12'd4095, 11'sd1023,  32'd20,    1'b1,
        '{1'b1, waq_pkg::CODE_LOW_OIL, 13'sd4095, waq_pkg::COLOR_YELLOW, 2'd3, 1'b0}},
      '{12'd4095, -11'sd256,  32'd5010,  1'b1,
        '{1'b0, waq_pkg::CODE_NONE, 13'sd0, 16'h0000, 2'd2, 1'b0}},
      '{12'd300,  -11'sd256,  32'd5011,  1'b0, '0},
      '{12'd300,  -11'sd256,  32'd10011, 1'b0, '0},
      '{12'd300,  -11'sd256,  32'd10012, 1'b1,
        '{1'b1, waq_pkg::CODE_HOT, -13'sd256, waq_pkg::COLOR_RED, 2'd1, 1'b0}},
      '{12'd300,  -11'sd256,  32'd15012, 1'b1,
        '{1'b0, waq_pkg::CODE_NONE, 13'sd0, 16'h0000, 2'd0, 1'b1}},
      '{12'd300,  -11'sd256,  32'd15013, 1'b0, '0},
      '{12'd0,    11'sd0,     32'hFFFF_FF00, 1'b0, '0},
      '{12'd0,    11'sd0,     32'h0000_1000, 1'b0, '0},
      '{12'd0,    11'sd0,     32'h0000_1288, 1'b0, '0},
      '{12'd100,  11'sd0,     32'h0000_2610, 1'b1,
        '{1'b0, waq_pkg::CODE_NONE, 13'sd0, 16'h0000, 2'd0, 1'b1}},
      '{12'd551,  11'sd231,   32'h0000_2611, 1'b0, '0},
      '{12'd550,  11'sd230,   32'h0000_2612, 1'b0, '0},
      '{12'd4095, 11'sd1023,  32'h0000_2613, 1'b1,
        '{1'b1, waq_pkg::CODE_HIGH_OIL, 13'sd4095, waq_pkg::COLOR_ORANGE, 2'd2, 1'b0}}
   };

   // Tell whether the condition behind a code holds for this tick
   function automatic logic alarm_on(input logic [waq_pkg::CODE_BITS-1:0] code,
                                     input logic [waq_pkg::OIL_BITS-1:0] oil,
                                     input logic signed [waq_pkg::COOL_BITS-1:0] cool);
      case (code)
         waq_pkg::CODE_LOW_OIL:  return oil < lim_low_oil;
         waq_pkg::CODE_HIGH_OIL: return oil > lim_high_oil;
         waq_pkg::CODE_HOT:      return cool > lim_hot;
         default:                return 1'b0;
      endcase
   endfunction

   // Append a code unless it already waits
   function automatic void enqueue(input logic [waq_pkg::CODE_BITS-1:0] code);
      for (int i = 0; i < shadow_len; i++)
         if (shadow_codes[i] == code) return;
      if (shadow_len < waq_pkg::QDEPTH) begin
         shadow_codes[shadow_len] = code;
         shadow_len++;
      end
   endfunction

   // Drop the head warning
   function automatic void retire();
      if (shadow_len == 0) return;
      for (int i = 1; i < waq_pkg::QDEPTH; i++)
         shadow_codes[i-1] = shadow_codes[i];
      shadow_codes[waq_pkg::QDEPTH-1] = waq_pkg::CODE_NONE;
      shadow_len--;
   endfunction

   // Advance the shadow by one tick and return the status it shows
   function automatic panel_status_type annunciate(
         input logic [waq_pkg::OIL_BITS-1:0] oil,
         input logic signed [waq_pkg::COOL_BITS-1:0] cool,
         input logic [waq_pkg::NOW_BITS-1:0] now);
      panel_status_type st;
      logic [waq_pkg::NOW_BITS-1:0] elapsed;
      st = '0;
      if (alarm_on(waq_pkg::CODE_LOW_OIL, oil, cool)) enqueue(waq_pkg::CODE_LOW_OIL);
      if (alarm_on(waq_pkg::CODE_HIGH_OIL, oil, cool)) enqueue(waq_pkg::CODE_HIGH_OIL);
      if (alarm_on(waq_pkg::CODE_HOT, oil, cool)) enqueue(waq_pkg::CODE_HOT);

      elapsed = now - shadow_since;
      if (!shadow_active) begin
         if (shadow_len != 0) begin
            shadow_since  = now;
            shadow_active = 1'b1;
         end
      end else if (shadow_len == 0) begin
         shadow_active = 1'b0;
      end else if (elapsed >= min_show) begin
         if (shadow_len > 1) begin
            retire();
            shadow_active = 1'b0;
         end else if (!alarm_on(shadow_codes[0], oil, cool)) begin
            retire();
            shadow_active = 1'b0;
            st.go_home    = 1'b1;
         end else begin
            shadow_since = now;
         end
      end

      // Show the head with its live sensor value
      if (shadow_active && shadow_len != 0) begin
         st.showing    = 1'b1;
         st.warn_code  = shadow_codes[0];
         st.warn_color = shade[shadow_codes[0]];
         case (shadow_codes[0]) inside
            waq_pkg::CODE_LOW_OIL, waq_pkg::CODE_HIGH_OIL: st.warn_value = {1'b0, oil};
            waq_pkg::CODE_HOT:
               st.warn_value = {{2{cool[waq_pkg::COOL_BITS-1]}}, cool};
            default: st.warn_value = '0;
         endcase
      end
      st.pending = shadow_len;
      return st;
   endfunction

   // Report one field that differs
   function automatic void judge(input string field, input logic signed [16:0] want,
                                 input logic signed [16:0] seen);
      if (seen !== want) begin
         $error("%s: expected %0d, actual %0d", field, want, seen);
         fault_count++;
      end
   endfunction

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit
   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   // Stall the response side in random bursts, none in the last part
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
      end
   end

   // Check each response against the oldest expected status
   always @(posedge clock) begin
      panel_status_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (status_due.size() == 0) begin
            $error("response with no request outstanding");
            fault_count++;
         end else begin
            want = status_due.pop_front();
            judge("showing", want.showing, rsp_bus.showing);
            judge("warn_code", want.warn_code, rsp_bus.warn_code);
            judge("warn_value", want.warn_value, rsp_bus.warn_value);
            judge("warn_color", want.warn_color, rsp_bus.warn_color);
            judge("pending", want.pending, rsp_bus.pending);
            judge("go_home", want.go_home, rsp_bus.go_home);
         end
      end
   end

   // Offer one request, hold it until taken, then log its expected status
   task automatic send_tick(input logic [waq_pkg::OIL_BITS-1:0] oil,
                            input logic signed [waq_pkg::COOL_BITS-1:0] cool,
                            input logic [waq_pkg::NOW_BITS-1:0] now,
                            input logic typed, input panel_status_type want);
      panel_status_type predicted;
      @(negedge clock);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.oil_kpa   <= oil;
      req_bus.coolant_f <= cool;
      req_bus.now_ms    <= now;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predicted = annunciate(oil, cool, now);
      status_due.push_back(typed ? want : predicted);
   endtask

   // Drop valid and wait until every expected status has come back
   task automatic settle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (status_due.size() != 0) @(posedge clock);
      repeat (2) @(negedge clock);
   endtask

   // APB write: setup cycle, then access cycle
   task automatic csr_write(input logic [1:0] index,
                            input logic [waq_pkg::CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Reprogram all four limits once the block is idle
   task automatic program_limits(input logic [waq_pkg::OIL_BITS-1:0] low,
                                 input logic [waq_pkg::OIL_BITS-1:0] high,
                                 input logic signed [waq_pkg::COOL_BITS-1:0] hot,
                                 input logic [waq_pkg::SHOW_BITS-1:0] show);
      settle();
      csr_write(waq_pkg::REG_LOW_OIL, {20'b0, low});
      lim_low_oil = low;
      csr_write(waq_pkg::REG_HIGH_OIL, {20'b0, high});
      lim_high_oil = high;
      csr_write(waq_pkg::REG_HOT, {21'b0, hot});
      lim_hot = hot;
      csr_write(waq_pkg::REG_MIN_SHOW, {16'b0, show});
      min_show = show;
   endtask

   // Random ticks: samples cluster around the limits, time mostly creeps forward
   task automatic run_ticks(input int count);
      logic [waq_pkg::OIL_BITS-1:0] oil;
      logic signed [waq_pkg::COOL_BITS-1:0] cool;
      int hot_i;
      int roll;
      hot_i = int'(lim_hot);
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 7);
         oil  = waq_pkg::OIL_BITS'($urandom_range(0, 4095));
         if (roll < 2 && lim_low_oil != 0)
            oil = waq_pkg::OIL_BITS'($urandom_range(0, lim_low_oil - 1));
         else if (roll < 4 && lim_high_oil != '1)
            oil = waq_pkg::OIL_BITS'($urandom_range(lim_high_oil + 1, 4095));
         else if (roll == 4)
            oil = ($urandom_range(0, 1) != 0) ? lim_low_oil : lim_high_oil;
         else if (roll > 4 && roll < 7 && lim_low_oil <= lim_high_oil)
            oil = waq_pkg::OIL_BITS'($urandom_range(lim_low_oil, lim_high_oil));

         roll = $urandom_range(0, 7);
         cool = waq_pkg::COOL_BITS'($urandom_range(0, 1279) - 256);
         if (roll < 4)
            cool = waq_pkg::COOL_BITS'($urandom_range(0, hot_i + 256) - 256);
         else if (roll < 6 && hot_i < 1023)
            cool = waq_pkg::COOL_BITS'($urandom_range(hot_i + 1, 1023));
         else if (roll == 6)
            cool = lim_hot;

         if ($urandom_range(0, 31) == 0)
            clock_ms = $urandom();
         else
            clock_ms += $urandom_range(0, 2 * min_show + 3);

         send_tick(oil, cool, clock_ms, 1'b0, '0);
      end
   endtask

   // Main sequence
   initial begin
      logic [waq_pkg::OIL_BITS-1:0] low;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.oil_kpa   = '0;
      req_bus.coolant_f = '0;
      req_bus.now_ms    = '0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed walk with the reset limits
      for (int i = 0; i < 16; i++)
         send_tick(directed_ticks[i].oil, directed_ticks[i].cool, directed_ticks[i].now,
                   directed_ticks[i].typed, directed_ticks[i].want);

      // Reset limits, then both extremes, then random settings
      clock_ms = 32'h0000_3000;
      program_limits(waq_pkg::LOW_OIL_RESET, waq_pkg::HIGH_OIL_RESET, waq_pkg::HOT_RESET,
                     waq_pkg::MIN_SHOW_RESET);
      run_ticks(90);
      program_limits(12'd0, 12'd4095, 11'sd1023, 16'd0);
      run_ticks(60);
      program_limits(12'd4095, 12'd0, -11'sd256, 16'd65535);
      run_ticks(90);
      for (int p = 0; p < 3; p++) begin
         low = waq_pkg::OIL_BITS'($urandom_range(0, 1500));
         program_limits(low, waq_pkg::OIL_BITS'($urandom_range(low, 4095)),
                        waq_pkg::COOL_BITS'($urandom_range(0, 1279) - 256),
                        waq_pkg::SHOW_BITS'($urandom_range(0, 40)));
         if (p == 2) calm = 1'b1;
         run_ticks(100);
      end

      settle();
      repeat (5) @(posedge clock);
      if (fault_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
